FILE: rtl/pcsp_pkg.sv
// shared types, codes and command decode for the picture command stream parser
`default_nettype none
package pcsp_pkg;

   // bytes at or above this value are commands
   localparam logic [7:0] CMD_BASE        = 8'hf0;
   localparam logic [7:0] OP_COLOR        = 8'hf0;
   localparam logic [7:0] OP_SCREEN_OFF   = 8'hf1;
   localparam logic [7:0] OP_PRIO         = 8'hf2;
   localparam logic [7:0] OP_PRIO_OFF     = 8'hf3;
   localparam logic [7:0] OP_Y_CORNER     = 8'hf4;
   localparam logic [7:0] OP_X_CORNER     = 8'hf5;
   localparam logic [7:0] OP_ABS_LINE     = 8'hf6;
   localparam logic [7:0] OP_SHORT_LINE   = 8'hf7;
   localparam logic [7:0] OP_FILL         = 8'hf8;
   localparam logic [7:0] OP_PATTERN_SET  = 8'hf9;
   localparam logic [7:0] OP_PLOT         = 8'hfa;
   localparam logic [7:0] OP_COLOR_PRIO   = 8'hfc;
   localparam logic [7:0] OP_END          = 8'hff;

   // pattern code bit that puts a pattern number ahead of every plot
   localparam int unsigned PAT_NUMBER_BIT = 5;

   localparam int unsigned EVENT_W = 4;
   localparam int unsigned PHASE_W = 2;

   typedef logic [EVENT_W-1:0] event_type;

   localparam event_type EV_COLOR_ON    = 4'd0;
   localparam event_type EV_SCREEN_OFF  = 4'd1;
   localparam event_type EV_PRIO_ON     = 4'd2;
   localparam event_type EV_PRIO_OFF    = 4'd3;
   localparam event_type EV_PATTERN     = 4'd4;
   localparam event_type EV_COLOR_PRIO  = 4'd5;
   localparam event_type EV_END         = 4'd6;
   localparam event_type EV_Y_CORNER    = 4'd7;
   localparam event_type EV_X_CORNER    = 4'd8;
   localparam event_type EV_ABS_LINE    = 4'd9;
   localparam event_type EV_SHORT_LINE  = 4'd10;
   localparam event_type EV_RUN_BYTE    = 4'd11;
   localparam event_type EV_FILL        = 4'd12;
   localparam event_type EV_PLOT        = 4'd13;

   typedef logic [PHASE_W-1:0] phase_type;

   localparam phase_type PH_FIRST  = 2'd0;
   localparam phase_type PH_SECOND = 2'd1;
   localparam phase_type PH_THIRD  = 2'd2;

   typedef enum logic [7:0] {
      CMD_IDLE  = 8'b0000_0001,
      CMD_COLOR = 8'b0000_0010,
      CMD_PRIO  = 8'b0000_0100,
      CMD_PSET  = 8'b0000_1000,
      CMD_CPRIO = 8'b0001_0000,
      CMD_FILL  = 8'b0010_0000,
      CMD_RUN   = 8'b0100_0000,
      CMD_PLOT  = 8'b1000_0000
   } cmd_type;

   typedef struct packed {
      cmd_type   cmd;
      logic      emit;
      event_type ev;
      logic      fin;
   } decode_type;

   // decode of one command byte
   function automatic decode_type decode_command(input logic [7:0] op);
      decode_type d;
      d.cmd  = CMD_IDLE;
      d.emit = 1'b0;
      d.ev   = EV_COLOR_ON;
      d.fin  = 1'b0;
      case (op)
         OP_COLOR:       d.cmd = CMD_COLOR;
         OP_SCREEN_OFF: begin
            d.emit = 1'b1;
            d.ev   = EV_SCREEN_OFF;
         end
         OP_PRIO:        d.cmd = CMD_PRIO;
         OP_PRIO_OFF: begin
            d.emit = 1'b1;
            d.ev   = EV_PRIO_OFF;
         end
         OP_Y_CORNER: begin
            d.cmd  = CMD_RUN;
            d.emit = 1'b1;
            d.ev   = EV_Y_CORNER;
         end
         OP_X_CORNER: begin
            d.cmd  = CMD_RUN;
            d.emit = 1'b1;
            d.ev   = EV_X_CORNER;
         end
         OP_ABS_LINE: begin
            d.cmd  = CMD_RUN;
            d.emit = 1'b1;
            d.ev   = EV_ABS_LINE;
         end
         OP_SHORT_LINE: begin
            d.cmd  = CMD_RUN;
            d.emit = 1'b1;
            d.ev   = EV_SHORT_LINE;
         end
         OP_FILL:        d.cmd = CMD_FILL;
         OP_PATTERN_SET: d.cmd = CMD_PSET;
         OP_PLOT:        d.cmd = CMD_PLOT;
         OP_COLOR_PRIO:  d.cmd = CMD_CPRIO;
         OP_END: begin
            d.emit = 1'b1;
            d.ev   = EV_END;
            d.fin  = 1'b1;
         end
         default:        d.cmd = CMD_IDLE;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/pcsp_if.sv
// valid/ready channel interfaces for stream bytes and parser events
`default_nettype none
interface pcsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_in_buffer;

   modport source (output valid, output in_byte, output last_in_buffer, input ready);
   modport sink (input valid, input in_byte, input last_in_buffer, output ready);
endinterface

interface pcsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_res;
   logic [7:0] arg_a;
   logic [7:0] arg_b;

   modport source (output valid, output event_res, output arg_a, output arg_b, input ready);
   modport sink (input valid, input event_res, input arg_a, input arg_b, output ready);
endinterface
`default_nettype wire

FILE: rtl/picture_command_stream_parser_unit.sv
// picture command stream parser: one stream byte in, at most one drawing event out
// latency: an event is presented in the cycle after its byte transfer (one register stage)
// throughput: one byte per cycle; the byte decode and state update sit between the
//   parser state registers and the event register, so back-to-back transfers run freely
// a byte is taken whenever the event register is empty or being drained this cycle
// reset (synchronous, active high) returns the parser to command position, clears all
//   held state and empties the event register
`default_nettype none
module picture_command_stream_parser_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   pcsp_req_if.sink   req_chan,
   pcsp_rsp_if.source rsp_chan
);
   import pcsp_pkg::*;

   // parser state
   cmd_type     cmd_ff,            cmd_in;
   phase_type   phase_ff,          phase_in;
   logic [7:0]  held_ff,           held_in;
   logic [7:0]  pat_code_ff,       pat_code_in;
   logic [6:0]  pat_num_ff,        pat_num_in;
   logic        finished_ff,       finished_in;

   // event register
   logic        rsp_valid_ff,      rsp_valid_in;
   event_type   rsp_event_ff,      rsp_event_in;
   logic [7:0]  rsp_arg_a_ff,      rsp_arg_a_in;
   logic [7:0]  rsp_arg_b_ff,      rsp_arg_b_in;

   logic        req_xfer;
   logic        is_cmd;
   logic        emit;
   event_type   ev;
   logic [7:0]  arg_a;
   logic [7:0]  arg_b;
   decode_type  dec;
   logic [7:0]  b;

   // input side stalls only when a finished event is still waiting and not being taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign b      = req_chan.in_byte;
   assign is_cmd = (b >= CMD_BASE);
   assign dec    = decode_command(b);

   // byte decode and next state
   always_comb begin
      cmd_in      = cmd_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      pat_code_in = pat_code_ff;
      pat_num_in  = pat_num_ff;
      finished_in = finished_ff;
      emit        = 1'b0;
      ev          = EV_COLOR_ON;
      arg_a       = 8'd0;
      arg_b       = 8'd0;

      if (!finished_ff) begin
         case (cmd_ff)
            // fixed argument bytes are taken as they are, even command values
            CMD_COLOR: begin
               cmd_in = CMD_IDLE;
               emit   = 1'b1;
               ev     = EV_COLOR_ON;
               arg_a  = b;
            end
            CMD_PRIO: begin
               cmd_in = CMD_IDLE;
               emit   = 1'b1;
               ev     = EV_PRIO_ON;
               arg_a  = b;
            end
            CMD_PSET: begin
               cmd_in      = CMD_IDLE;
               pat_code_in = b;
               emit        = 1'b1;
               ev          = EV_PATTERN;
               arg_a       = b;
               arg_b       = {1'b0, pat_num_ff};
            end
            CMD_CPRIO: begin
               if (phase_ff == PH_FIRST) begin
                  held_in  = b;
                  phase_in = PH_SECOND;
               end else begin
                  // color and priority pair, then the command carries on as a fill run
                  cmd_in   = CMD_FILL;
                  phase_in = PH_FIRST;
                  emit     = 1'b1;
                  ev       = EV_COLOR_PRIO;
                  arg_a    = held_ff;
                  arg_b    = b;
               end
            end
            default: begin
               if (is_cmd) begin
                  // new command; any half-built pair or plot is dropped
                  cmd_in      = dec.cmd;
                  phase_in    = PH_FIRST;
                  emit        = dec.emit;
                  ev          = dec.ev;
                  finished_in = dec.fin;
               end else begin
                  case (cmd_ff)
                     CMD_RUN: begin
                        emit  = 1'b1;
                        ev    = EV_RUN_BYTE;
                        arg_a = b;
                     end
                     CMD_FILL: begin
                        if (phase_ff == PH_FIRST) begin
                           held_in  = b;
                           phase_in = PH_SECOND;
                        end else begin
                           phase_in = PH_FIRST;
                           emit     = 1'b1;
                           ev       = EV_FILL;
                           arg_a    = held_ff;
                           arg_b    = b;
                        end
                     end
                     CMD_PLOT: begin
                        if (phase_ff == PH_FIRST && pat_code_ff[PAT_NUMBER_BIT]) begin
                           // pattern number byte ahead of the coordinates
                           pat_num_in = b[7:1];
                           phase_in   = PH_SECOND;
                           emit       = 1'b1;
                           ev         = EV_PATTERN;
                           arg_a      = pat_code_ff;
                           arg_b      = {1'b0, b[7:1]};
                        end else if (phase_ff == PH_FIRST || phase_ff == PH_SECOND) begin
                           held_in  = b;
                           phase_in = PH_THIRD;
                        end else begin
                           phase_in = PH_FIRST;
                           emit     = 1'b1;
                           ev       = EV_PLOT;
                           arg_a    = held_ff;
                           arg_b    = b;
                        end
                     end
                     // command position or unknown command: stray bytes are skipped
                     default: begin
                        emit = 1'b0;
                     end
                  endcase
               end
            end
         endcase
      end

      // last byte of a buffer: its event still goes out, then all state starts over
      if (req_chan.last_in_buffer) begin
         cmd_in      = CMD_IDLE;
         phase_in    = PH_FIRST;
         held_in     = 8'd0;
         pat_code_in = 8'd0;
         pat_num_in  = 7'd0;
         finished_in = 1'b0;
      end
   end

   // event register: loads on a byte transfer, empties when its event is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_event_in = rsp_event_ff;
      rsp_arg_a_in = rsp_arg_a_ff;
      rsp_arg_b_in = rsp_arg_b_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer) begin
         rsp_valid_in = emit;
         rsp_event_in = ev;
         rsp_arg_a_in = arg_a;
         rsp_arg_b_in = arg_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_IDLE;
         phase_ff     <= PH_FIRST;
         held_ff      <= 8'd0;
         pat_code_ff  <= 8'd0;
         pat_num_ff   <= 7'd0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            cmd_ff      <= cmd_in;
            phase_ff    <= phase_in;
            held_ff     <= held_in;
            pat_code_ff <= pat_code_in;
            pat_num_ff  <= pat_num_in;
            finished_ff <= finished_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_event_ff <= rsp_event_in;
      rsp_arg_a_ff <= rsp_arg_a_in;
      rsp_arg_b_ff <= rsp_arg_b_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.event_res = rsp_event_ff;
   assign rsp_chan.arg_a     = rsp_arg_a_ff;
   assign rsp_chan.arg_b     = rsp_arg_b_ff;

`ifndef ASSERT_OFF
   // a buffer's last byte leaves the parser in command position and not finished
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_chan.last_in_buffer |=> cmd_ff == CMD_IDLE && !finished_ff
         && phase_ff == PH_FIRST)
      else $error("parser state not cleared after last byte of buffer");

   // only pair, color-priority and plot commands ever sit past their first phase
   a_phase_owner: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_FIRST |-> cmd_ff == CMD_CPRIO || cmd_ff == CMD_FILL
         || cmd_ff == CMD_PLOT)
      else $error("sub phase set outside a multi-byte command");

   // third phase belongs to plot runs alone
   a_third_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_THIRD |-> cmd_ff == CMD_PLOT)
      else $error("third phase outside a plot run");

   // once finished no byte yields an event
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      req_xfer && finished_ff |=> !rsp_valid_ff)
      else $error("event produced after end command");

   // the command register stays one-hot
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(cmd_ff))
      else $error("command register lost one-hot coding");
`endif

endmodule
`default_nettype wire
